FILE: rtl/mlp_pkg.sv
// mlp_pkg: shared constants, command struct and sigmoid table for the mlp trainer
`default_nettype none
package mlp_pkg;

  localparam int NUM_INPUTS  = 4;
  localparam int NUM_HIDDEN  = 5;
  localparam int NUM_CLASSES = 3;
  localparam int WeightBits  = 32;

  localparam int N_HW = NUM_HIDDEN * NUM_INPUTS;
  localparam int N_OW = NUM_CLASSES * NUM_HIDDEN;

  localparam int HW_IDX_W = $clog2(N_HW);
  localparam int OW_IDX_W = $clog2(N_OW);
  localparam int H_W      = $clog2(NUM_HIDDEN);
  localparam int I_W      = $clog2(NUM_INPUTS);
  localparam int C_W      = $clog2(NUM_CLASSES);

  localparam int FEAT_W  = 18;
  localparam int SCORE_W = 16;
  localparam int ERR_W   = 18;
  localparam int RATE_W  = 16;
  localparam int B_W     = 20;
  localparam int DELTA_W = 20;

  localparam logic [1:0] MODE_TRAIN = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // operation codes, also used as controller state codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD    = 5'd2;
  localparam logic [OP_W-1:0] OP_HF      = 5'd3;
  localparam logic [OP_W-1:0] OP_HS      = 5'd4;
  localparam logic [OP_W-1:0] OP_OF      = 5'd5;
  localparam logic [OP_W-1:0] OP_OS      = 5'd6;
  localparam logic [OP_W-1:0] OP_ER      = 5'd7;
  localparam logic [OP_W-1:0] OP_PUB     = 5'd8;
  localparam logic [OP_W-1:0] OP_SO      = 5'd9;
  localparam logic [OP_W-1:0] OP_DL      = 5'd10;
  localparam logic [OP_W-1:0] OP_EM      = 5'd11;
  localparam logic [OP_W-1:0] OP_D1      = 5'd12;
  localparam logic [OP_W-1:0] OP_D2      = 5'd13;
  localparam logic [OP_W-1:0] OP_SY      = 5'd14;
  localparam logic [OP_W-1:0] OP_GH      = 5'd15;
  localparam logic [OP_W-1:0] OP_V1      = 5'd16;
  localparam logic [OP_W-1:0] OP_V2      = 5'd17;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            wb;    // second half of a multiply op: write back
    logic            zero;  // publish an all-zero result
    logic [H_W-1:0]  h;
    logic [I_W-1:0]  i;
    logic [C_W-1:0]  c;
  } cmd_t;

  function automatic logic [15:0] sig_tab(input logic [4:0] k);
    logic [15:0] v;
    unique case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

  // mag is |x| clamped to 8.0, neg is the sign of x
  function automatic logic [15:0] sigm(input logic neg, input logic [19:0] mag);
    logic [16:0] s;
    logic [4:0]  k;
    logic [15:0] t0;
    logic [15:0] t1;
    logic [31:0] p;
    k  = {1'b0, mag[18:15]};
    t0 = sig_tab(k);
    t1 = sig_tab(k + 5'd1);
    p  = 32'(t1 - t0) * 32'(mag[14:0]) + 32'd16384;
    if (mag[19]) begin
      s = {1'b0, sig_tab(5'd16)};
    end else begin
      s = {1'b0, t0} + 17'(p >> 15);
    end
    return neg ? 16'(17'd65536 - s) : s[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mlp_ctrl.sv
// mlp_ctrl: sequencer that steps the shared datapath through forward and update passes
`default_nettype none
module mlp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [1:0]   mode,
  output logic              busy,
  output mlp_pkg::cmd_t     cmd
);
  import mlp_pkg::*;

  logic [OP_W-1:0] state;
  logic            phase;
  logic [H_W-1:0]  h;
  logic [I_W-1:0]  i;
  logic [C_W-1:0]  c;
  logic            train;
  logic            zero;
  logic            h_last;
  logic            i_last;
  logic            c_last;

  assign h_last = (h == H_W'(NUM_HIDDEN - 1));
  assign i_last = (i == I_W'(NUM_INPUTS - 1));
  assign c_last = (c == C_W'(NUM_CLASSES - 1));
  assign busy   = (state != OP_NONE);

  always_comb begin
    cmd.op = state;
    if (state == OP_NONE) begin
      if (!start) cmd.op = OP_NONE;
      else if (mode == MODE_LOAD) cmd.op = OP_LOAD;
      else cmd.op = OP_CAPTURE;
    end
    cmd.wb   = phase;
    cmd.zero = zero;
    cmd.h    = h;
    cmd.i    = i;
    cmd.c    = c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OP_NONE;
      phase <= 1'b0;
      h     <= '0;
      i     <= '0;
      c     <= '0;
      train <= 1'b0;
      zero  <= 1'b0;
    end else begin
      case (state)
        OP_NONE: begin
          if (start) begin
            train <= (mode == MODE_TRAIN);
            zero  <= (mode == MODE_LOAD);
            h     <= '0;
            i     <= '0;
            c     <= '0;
            phase <= 1'b0;
            state <= (mode == MODE_LOAD) ? OP_PUB : OP_HF;
          end
        end
        OP_HF: begin
          phase <= ~phase;
          if (phase) begin
            if (i_last) begin
              i     <= '0;
              state <= OP_HS;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        OP_HS: begin
          if (h_last) begin
            h     <= '0;
            state <= OP_OF;
          end else begin
            h     <= h + 1'b1;
            state <= OP_HF;
          end
        end
        OP_OF: begin
          phase <= ~phase;
          if (phase) begin
            if (h_last) begin
              h     <= '0;
              state <= OP_OS;
            end else begin
              h <= h + 1'b1;
            end
          end
        end
        OP_OS: begin
          if (c_last) begin
            c     <= '0;
            state <= OP_ER;
          end else begin
            c     <= c + 1'b1;
            state <= OP_OF;
          end
        end
        OP_ER: begin
          phase <= ~phase;
          if (phase) begin
            if (c_last) begin
              c     <= '0;
              state <= OP_PUB;
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        OP_PUB: begin
          state <= train ? OP_SO : OP_NONE;
        end
        OP_SO: begin
          phase <= ~phase;
          if (phase) state <= OP_DL;
        end
        OP_DL: begin
          phase <= ~phase;
          if (phase) begin
            if (c_last) begin
              c     <= '0;
              state <= OP_EM;
            end else begin
              c     <= c + 1'b1;
              state <= OP_SO;
            end
          end
        end
        OP_EM: begin
          phase <= ~phase;
          if (phase) state <= OP_D1;
        end
        OP_D1: begin
          phase <= ~phase;
          if (phase) state <= OP_D2;
        end
        OP_D2: begin
          phase <= ~phase;
          if (phase) begin
            if (c_last) begin
              c     <= '0;
              state <= OP_SY;
            end else begin
              c     <= c + 1'b1;
              state <= OP_EM;
            end
          end
        end
        OP_SY: begin
          phase <= ~phase;
          if (phase) state <= OP_GH;
        end
        OP_GH: begin
          phase <= ~phase;
          if (phase) begin
            i     <= '0;
            state <= OP_V1;
          end
        end
        OP_V1: begin
          phase <= ~phase;
          if (phase) state <= OP_V2;
        end
        OP_V2: begin
          phase <= ~phase;
          if (phase) begin
            if (i_last) begin
              i <= '0;
              if (h_last) begin
                h     <= '0;
                state <= OP_NONE;
              end else begin
                h     <= h + 1'b1;
                state <= OP_EM;
              end
            end else begin
              i     <= i + 1'b1;
              state <= OP_V1;
            end
          end
        end
        default: state <= OP_NONE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mlp_datapath.sv
// mlp_datapath: weight stores, shared multiplier, sigmoid unit and result registers
`default_nettype none
module mlp_datapath #(
  parameter int WEIGHT_BITS = mlp_pkg::WeightBits
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  mlp_pkg::cmd_t                    cmd,
  input  wire logic signed [17:0]          feature_0,
  input  wire logic signed [17:0]          feature_1,
  input  wire logic signed [17:0]          feature_2,
  input  wire logic signed [17:0]          feature_3,
  input  wire logic [1:0]                  target_class,
  input  wire logic [5:0]                  weight_index,
  input  wire logic signed [31:0]          weight_value,
  input  wire logic                        wr_en,
  input  wire logic                        wr_index,
  input  wire logic [15:0]                 wr_data,
  output logic [15:0]                      score_0,
  output logic [15:0]                      score_1,
  output logic [15:0]                      score_2,
  output logic [1:0]                       predicted_class,
  output logic [17:0]                      squared_error,
  output logic                             done
);
  import mlp_pkg::*;

  localparam int AW = (WEIGHT_BITS + 8 > 40) ? WEIGHT_BITS + 8 : 40;
  localparam int PW = AW + B_W;

  logic signed [WEIGHT_BITS-1:0] hw [N_HW];
  logic signed [WEIGHT_BITS-1:0] ow [N_OW];
  logic [RATE_W-1:0]             rate_o;
  logic [RATE_W-1:0]             rate_h;

  logic signed [FEAT_W-1:0]  x [NUM_INPUTS];
  logic [SCORE_W-1:0]        y [NUM_HIDDEN];
  logic [SCORE_W-1:0]        o [NUM_CLASSES];
  logic signed [DELTA_W-1:0] delta [NUM_CLASSES];
  logic [1:0]                tc;

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] tmp;
  logic signed [AW-1:0] e;
  logic signed [AW-1:0] gh;
  logic signed [PW-1:0] prod;

  logic signed [AW-1:0]  a;
  logic signed [B_W-1:0] b;
  logic signed [AW-1:0]  res;
  logic [HW_IDX_W-1:0]   hidx;
  logic [OW_IDX_W-1:0]   oidx;
  logic signed [18:0]    o_s;
  logic signed [18:0]    t_s;
  logic signed [18:0]    y_s;
  logic signed [AW-1:0]  acc_abs;
  logic [19:0]           mag;
  logic [15:0]           sig_val;
  logic [1:0]            pred;
  logic [SCORE_W-1:0]    best;
  logic signed [AW-1:0]  load_val;

  function automatic logic signed [WEIGHT_BITS-1:0] wsat(input logic signed [AW:0] v);
    logic [AW-WEIGHT_BITS+1:0] top;
    top = v[AW:WEIGHT_BITS-1];
    if ((&top) || !(|top)) return v[WEIGHT_BITS-1:0];
    return v[AW] ? {1'b1, {(WEIGHT_BITS-1){1'b0}}} : {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  endfunction

  assign hidx = HW_IDX_W'(int'(cmd.h) * NUM_INPUTS + int'(cmd.i));
  assign oidx = OW_IDX_W'(int'(cmd.c) * NUM_HIDDEN + int'(cmd.h));
  assign res  = AW'(prod >>> 16);

  always_comb begin
    o_s = 19'(o[cmd.c]);
    t_s = (2'(cmd.c) == tc) ? 19'sd65536 : 19'sd0;
    y_s = 19'(y[cmd.h]);
    a   = '0;
    b   = '0;
    case (cmd.op)
      OP_HF: begin a = AW'(hw[hidx]);   b = B_W'(x[cmd.i]); end
      OP_OF: begin a = AW'(ow[oidx]);   b = B_W'(y_s); end
      OP_ER: begin a = AW'(o_s - t_s);  b = B_W'(o_s - t_s); end
      OP_SO: begin a = AW'(o_s);        b = B_W'(19'sd65536 - o_s); end
      OP_DL: begin a = AW'(t_s - o_s);  b = tmp[B_W-1:0]; end
      OP_EM: begin a = AW'(ow[oidx]);   b = B_W'(delta[cmd.c]); end
      OP_D1: begin a = AW'(delta[cmd.c]); b = B_W'(y_s); end
      OP_D2: begin a = tmp;             b = B_W'({1'b0, rate_o}); end
      OP_SY: begin a = AW'(y_s);        b = B_W'(19'sd65536 - y_s); end
      OP_GH: begin a = e;               b = tmp[B_W-1:0]; end
      OP_V1: begin a = gh;              b = B_W'(x[cmd.i]); end
      OP_V2: begin a = tmp;             b = B_W'({1'b0, rate_h}); end
      default: begin a = '0; b = '0; end
    endcase
  end

  // sigmoid input magnitude clamped at 8.0
  always_comb begin
    acc_abs = acc[AW-1] ? -acc : acc;
    mag     = (acc_abs >= AW'(20'h80000)) ? 20'h80000 : acc_abs[19:0];
    sig_val = sigm(acc[AW-1], mag);
  end

  // first strictly largest score
  always_comb begin
    best = '0;
    pred = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (o[k] > best) begin
        best = o[k];
        pred = 2'(k);
      end
    end
  end

  assign load_val = AW'(weight_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_o <= 16'd6554;
      rate_h <= 16'd6554;
      done   <= 1'b0;
      for (int k = 0; k < N_HW; k++) hw[k] <= '0;
      for (int k = 0; k < N_OW; k++) ow[k] <= '0;
    end else begin
      done <= (cmd.op == OP_PUB);
      if (wr_en) begin
        if (wr_index) rate_h <= wr_data;
        else rate_o <= wr_data;
      end
      if (!cmd.wb) prod <= a * b;
      case (cmd.op)
        OP_CAPTURE: begin
          x[0] <= feature_0;
          x[1] <= feature_1;
          x[2] <= feature_2;
          x[3] <= feature_3;
          tc   <= target_class;
        end
        OP_LOAD: begin
          if (weight_index < 6'(N_HW)) begin
            hw[HW_IDX_W'(weight_index)] <= wsat((AW+1)'(load_val));
          end else if (weight_index < 6'(N_HW + N_OW)) begin
            ow[OW_IDX_W'(weight_index - 6'(N_HW))] <= wsat((AW+1)'(load_val));
          end
        end
        OP_HF: if (cmd.wb) acc <= ((cmd.i == '0) ? '0 : acc) + res;
        OP_OF: if (cmd.wb) acc <= ((cmd.h == '0) ? '0 : acc) + res;
        OP_ER: if (cmd.wb) acc <= ((cmd.c == '0) ? '0 : acc) + res;
        OP_HS: y[cmd.h] <= sig_val;
        OP_OS: o[cmd.c] <= sig_val;
        OP_PUB: begin
          score_0         <= cmd.zero ? '0 : o[0];
          score_1         <= cmd.zero ? '0 : o[1];
          score_2         <= cmd.zero ? '0 : o[2];
          predicted_class <= cmd.zero ? '0 : pred;
          squared_error   <= cmd.zero ? '0 : acc[ERR_W-1:0];
        end
        OP_SO, OP_D1, OP_SY, OP_V1: if (cmd.wb) tmp <= res;
        OP_DL: if (cmd.wb) delta[cmd.c] <= res[DELTA_W-1:0];
        OP_EM: if (cmd.wb) e <= ((cmd.c == '0) ? '0 : e) + res;
        OP_D2: if (cmd.wb) ow[oidx] <= wsat((AW+1)'(ow[oidx]) + (AW+1)'(res));
        OP_GH: if (cmd.wb) gh <= res;
        OP_V2: if (cmd.wb) hw[hidx] <= wsat((AW+1)'(hw[hidx]) + (AW+1)'(res));
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mlp_backprop_trainer_core.sv
// mlp_backprop_trainer_core: top level of the 4-5-3 perceptron trainer
`default_nettype none
// Usage: a request is taken on a clock edge with start high and busy low. mode selects
// train (0), infer (1 or 3) or load one weight (2). busy stays high while the request
// is worked on; done pulses for one cycle with score_*, predicted_class and
// squared_error valid in that cycle. The receiver cannot stall; it must take the result.
// All products of the network go through one shared multiplier, each as a multiply and
// then a shift with accumulate or write back; each sigmoid takes a state of its own.
//   load  : in-range weight written at the accepting edge, then state PUB registers done
//   infer : 20 hidden MACs, 15 output MACs, 3 error terms, then PUB registers done
//   train : result as for infer, then the weight update while busy
// Learning rates are written through wr_en/wr_index/wr_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Reset: both weight stores clear to zero, both rates return to 6554, busy drops.
module mlp_backprop_trainer_core #(
  parameter int WEIGHT_BITS = mlp_pkg::WeightBits
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic signed [17:0] feature_0,
  input  wire logic signed [17:0] feature_1,
  input  wire logic signed [17:0] feature_2,
  input  wire logic signed [17:0] feature_3,
  input  wire logic [1:0]         target_class,
  input  wire logic [5:0]         weight_index,
  input  wire logic signed [31:0] weight_value,
  input  wire logic               wr_en,
  input  wire logic               wr_index,
  input  wire logic [15:0]        wr_data,
  output logic                    done,
  output logic [15:0]             score_0,
  output logic [15:0]             score_1,
  output logic [15:0]             score_2,
  output logic [1:0]              predicted_class,
  output logic [17:0]             squared_error
);
  import mlp_pkg::*;

  cmd_t cmd;

  mlp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .busy  (busy),
    .cmd   (cmd)
  );

  mlp_datapath #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .feature_0       (feature_0),
    .feature_1       (feature_1),
    .feature_2       (feature_2),
    .feature_3       (feature_3),
    .target_class    (target_class),
    .weight_index    (weight_index),
    .weight_value    (weight_value),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .score_0         (score_0),
    .score_1         (score_1),
    .score_2         (score_2),
    .predicted_class (predicted_class),
    .squared_error   (squared_error),
    .done            (done)
  );

  // a result never follows in the very next cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted request always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // every result comes out of a busy sequence
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // a load result has all-zero scores and squared error
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_LOAD) |=> ##1
    (score_0 == '0 && score_1 == '0 && score_2 == '0 && squared_error == '0))
    else $error("load request gave a non-zero result");

endmodule
`default_nettype wire

FILE: test/testbench.sv
// testbench for the 4-5-3 perceptron trainer: random loads, inference and training checked
`timescale 1ns / 100ps
module testbench;
  import mlp_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0] MODE_INFER = 2'd1;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic REG_RATE_OUT = 1'b0;
  localparam logic REG_RATE_HID = 1'b1;

  typedef struct {
    logic [1:0]         mode;
    logic signed [17:0] feat [NUM_INPUTS];
    logic [1:0]         target;
    logic [5:0]         widx;
    logic signed [31:0] wval;
  } request_t;

  typedef struct {
    logic [15:0] score [NUM_CLASSES];
    logic [1:0]  pred;
    logic [17:0] err;
  } outcome_t;

  class trainer_model;
    longint hid_w [N_HW];
    longint out_w [N_OW];
    longint rate_out;
    longint rate_hid;
    longint lut [17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
                         64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
    outcome_t expected_outcomes [$];
    int errors;

    function new();
      foreach (hid_w[k]) hid_w[k] = 0;
      foreach (out_w[k]) out_w[k] = 0;
      rate_out = 6554;
      rate_hid = 6554;
      errors = 0;
    endfunction

    function longint fmul(longint a, longint b);
      longint lo;
      lo = a & 64'hFFFF;
      return (a >>> 16) * b + ((lo * b) >>> 16);
    endfunction

    function longint clamp_w(longint v);
      longint mx;
      mx = (64'sd1 <<< 31) - 1;
      if (v > mx) return mx;
      if (v < -mx - 1) return -mx - 1;
      return v;
    endfunction

    function longint squash(longint x);
      longint a, s, f;
      int k;
      a = (x < 0) ? -x : x;
      if (a >= (64'sd8 <<< 16)) begin
        s = lut[16];
      end else begin
        k = int'(a >>> 15);
        f = a & 64'h7FFF;
        s = lut[k] + (((lut[k+1] - lut[k]) * f + 16384) >>> 15);
      end
      return (x < 0) ? 65536 - s : s;
    endfunction

    function longint slope(longint o);
      return (o * (65536 - o)) >>> 16;
    endfunction

    function void note_request(request_t r);
      outcome_t res;
      longint x [NUM_INPUTS];
      longint y [NUM_HIDDEN];
      longint o [NUM_CLASSES];
      longint t [NUM_CLASSES];
      longint dl [NUM_CLASSES];
      longint s, best, err, d, e, gh;
      res.pred = 0;
      res.err = 0;
      foreach (res.score[c]) res.score[c] = 0;
      if (r.mode == MODE_LOAD) begin
        if (r.widx < N_HW) hid_w[r.widx] = clamp_w(longint'(r.wval));
        else if (r.widx < N_HW + N_OW) out_w[r.widx - N_HW] = clamp_w(longint'(r.wval));
        expected_outcomes.push_back(res);
        return;
      end
      foreach (x[i]) x[i] = longint'(r.feat[i]);
      for (int h = 0; h < NUM_HIDDEN; h++) begin
        s = 0;
        for (int i = 0; i < NUM_INPUTS; i++) s += fmul(hid_w[h*NUM_INPUTS+i], x[i]);
        y[h] = squash(s);
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        s = 0;
        for (int h = 0; h < NUM_HIDDEN; h++) s += fmul(out_w[c*NUM_HIDDEN+h], y[h]);
        o[c] = squash(s);
        t[c] = (c == r.target) ? 65536 : 0;
      end
      best = 0;
      err = 0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        d = o[c] - t[c];
        if (o[c] > best) begin
          best = o[c];
          res.pred = c[1:0];
        end
        err += (d * d) >>> 16;
        res.score[c] = o[c][15:0];
      end
      res.err = err[17:0];
      expected_outcomes.push_back(res);
      if (r.mode != MODE_TRAIN) return;
      // output deltas taken against the weights before this step
      for (int c = 0; c < NUM_CLASSES; c++) dl[c] = ((t[c] - o[c]) * slope(o[c])) >>> 16;
      for (int h = 0; h < NUM_HIDDEN; h++) begin
        e = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          e += fmul(out_w[c*NUM_HIDDEN+h], dl[c]);
          out_w[c*NUM_HIDDEN+h] = clamp_w(out_w[c*NUM_HIDDEN+h]
                                  + fmul(fmul(dl[c], y[h]), rate_out));
        end
        gh = fmul(e, slope(y[h]));
        for (int i = 0; i < NUM_INPUTS; i++)
          hid_w[h*NUM_INPUTS+i] = clamp_w(hid_w[h*NUM_INPUTS+i]
                                  + fmul(fmul(gh, x[i]), rate_hid));
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp_o;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, score_0 %0d", $time, got.score[0]);
        errors++;
        return;
      end
      exp_o = expected_outcomes.pop_front();
      foreach (got.score[c])
        if (got.score[c] !== exp_o.score[c]) begin
          $display("%0t: score_%0d expected %0d actual %0d", $time, c, exp_o.score[c],
                   got.score[c]);
          errors++;
        end
      if (got.pred !== exp_o.pred) begin
        $display("%0t: predicted_class expected %0d actual %0d", $time, exp_o.pred, got.pred);
        errors++;
      end
      if (got.err !== exp_o.err) begin
        $display("%0t: squared_error expected %0d actual %0d", $time, exp_o.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] mode = '0;
  logic signed [17:0] feature_0 = '0, feature_1 = '0, feature_2 = '0, feature_3 = '0;
  logic [1:0] target_class = '0;
  logic [5:0] weight_index = '0;
  logic signed [31:0] weight_value = '0;
  logic wr_en = 1'b0;
  logic wr_index = 1'b0;
  logic [15:0] wr_data = '0;
  logic busy, done;
  logic [15:0] score_0, score_1, score_2;
  logic [1:0] predicted_class;
  logic [17:0] squared_error;

  trainer_model model = new();
  int cycles = 0;
  int sent = 0;

  mlp_backprop_trainer_core uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && done) begin
      got.score[0] = score_0;
      got.score[1] = score_1;
      got.score[2] = score_2;
      got.pred = predicted_class;
      got.err = squared_error;
      model.check_result(got);
    end
  end

  function automatic longint rand_signed(int bits);
    logic [31:0] r;
    r = $urandom;
    return longint'($signed(r)) >>> (32 - bits);
  endfunction

  task automatic send(request_t r);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= r.mode;
    feature_0 <= r.feat[0];
    feature_1 <= r.feat[1];
    feature_2 <= r.feat[2];
    feature_3 <= r.feat[3];
    target_class <= r.target;
    weight_index <= r.widx;
    weight_value <= r.wval;
    do @(posedge clk); while (busy);
    model.note_request(r);
    sent++;
  endtask

  // wait until every result is in and the weight update has finished
  task automatic drain();
    if (start) start <= 1'b0;
    do @(posedge clk); while (model.expected_outcomes.size() != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_rates(logic [15:0] r_out, logic [15:0] r_hid);
    drain();
    wr_en <= 1'b1;
    wr_index <= REG_RATE_OUT;
    wr_data <= r_out;
    @(posedge clk);
    model.rate_out = r_out;
    wr_index <= REG_RATE_HID;
    wr_data <= r_hid;
    @(posedge clk);
    model.rate_hid = r_hid;
    wr_en <= 1'b0;
  endtask

  function automatic request_t make_eval(logic [1:0] m, logic [1:0] tc);
    request_t r;
    r.mode = m;
    r.target = tc;
    foreach (r.feat[i]) r.feat[i] = ($urandom_range(0, 9) == 0)
        ? (($urandom_range(0, 1) != 0) ? 18'sh1FFFF : -18'sh20000)
        : 18'($urandom);
    r.widx = 6'($urandom);
    r.wval = $urandom;
    return r;
  endfunction

  function automatic request_t make_load(logic [5:0] idx, logic signed [31:0] val);
    request_t r;
    r = make_eval(MODE_LOAD, 2'($urandom));
    r.widx = idx;
    r.wval = val;
    return r;
  endfunction

  task automatic load_all(int mag_bits);
    for (int k = 0; k < N_HW + N_OW; k++) begin
      if ($urandom_range(0, 15) == 0) send(make_load(6'(k), $urandom));
      else send(make_load(6'(k), 32'(rand_signed($urandom_range(12, mag_bits)))));
    end
  endtask

  initial begin
    logic [15:0] rate_pairs [8][2];
    request_t r;
    rate_pairs = '{'{16'd0, 16'd0}, '{16'd65535, 16'd65535}, '{16'd6554, 16'd6554},
                   '{16'd65535, 16'd0}, '{16'd0, 16'd65535}, '{16'd30000, 16'd1000},
                   '{16'($urandom), 16'($urandom)}, '{16'd20000, 16'd50000}};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero weights, extremes, spare mode and target, stray load indexes
    send(make_eval(MODE_INFER, 2'd0));
    send(make_eval(MODE_TRAIN, 2'd1));
    send(make_load(6'd0, 32'sh7FFFFFFF));
    send(make_load(6'd19, -32'sh80000000));
    send(make_load(6'd20, 32'sh7FFFFFFF));
    send(make_load(6'd34, -32'sh80000000));
    send(make_load(6'd35, 32'sh12345678));
    send(make_load(6'd63, -32'sh1));
    r = make_eval(MODE_TRAIN, 2'd3);
    foreach (r.feat[i]) r.feat[i] = 18'sh1FFFF;
    send(r);
    r = make_eval(MODE_SPARE, 2'd2);
    foreach (r.feat[i]) r.feat[i] = -18'sh20000;
    send(r);
    send(make_eval(MODE_SPARE, 2'd3));
    send(make_eval(MODE_TRAIN, 2'd2));
    send(make_eval(MODE_INFER, 2'd1));
    send(make_load(6'd7, 32'sh00010000));
    send(make_load(6'd27, -32'sh00008000));
    send(make_eval(MODE_TRAIN, 2'd0));
    send(make_eval(MODE_INFER, 2'd3));

    for (int p = 0; p < 8; p++) begin
      set_rates(rate_pairs[p][0], rate_pairs[p][1]);
      load_all(p[0] ? 20 : 18);
      while (sent < ITEM_TARGET * (p + 1) / 8) begin
        case ($urandom_range(0, 19))
          0: send(make_load(6'($urandom), $urandom));
          1: send(make_load(6'($urandom_range(0, 34)), 32'(rand_signed(18))));
          2: send(make_eval(MODE_SPARE, 2'($urandom)));
          3, 4, 5, 6: send(make_eval(MODE_INFER, 2'($urandom)));
          default: send(make_eval(MODE_TRAIN, 2'($urandom_range(0, 2))));
        endcase
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (model.errors == 0 && model.expected_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mlp_pkg.sv
rtl/mlp_ctrl.sv
rtl/mlp_datapath.sv
rtl/mlp_backprop_trainer_core.sv
test/testbench.sv
